// ===== hdl/rms_pkg.sv =====
// Package: item types, codes and constants for the robot mode sequencer.
`timescale 1ns / 1ps
`default_nettype none

package rms_pkg;

  localparam int SUM_W = 28;
  typedef logic signed [SUM_W-1:0] wide_t;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  localparam logic [1:0] LED_NONE  = 2'd0;
  localparam logic [1:0] LED_SOLID = 2'd1;
  localparam logic [1:0] LED_FAST  = 2'd2;
  localparam logic [1:0] LED_SLOW  = 2'd3;

  localparam logic [2:0] OPEN_FRONT     = 3'd0;
  localparam logic [2:0] OPEN_RIGHT     = 3'd1;
  localparam logic [2:0] OPEN_RIGHT_ARC = 3'd2;
  localparam logic [2:0] OPEN_LEFT      = 3'd3;
  localparam logic [2:0] OPEN_LEFT_ARC  = 3'd4;
  localparam logic [2:0] OPEN_BACK      = 3'd5;

  localparam logic [1:0] STRAT_STRAIGHT = 2'd0;
  localparam logic [1:0] STRAT_PD       = 2'd1;

  localparam logic [2:0] REG_OPENING_KIND  = 3'd0;
  localparam logic [2:0] REG_STRATEGY_KIND = 3'd1;
  localparam logic [2:0] REG_PROP_GAIN     = 3'd2;
  localparam logic [2:0] REG_DERIV_GAIN    = 3'd3;
  localparam logic [2:0] REG_CRUISE_SPEED  = 3'd4;
  localparam logic [2:0] REG_ESCAPE_SPEED  = 3'd5;

  localparam logic [31:0] TURN_MS    = 32'd240;
  localparam logic [31:0] ARC_MS     = 32'd650;
  localparam logic [31:0] BACK_MS    = 32'd490;
  localparam logic [31:0] REVERSE_MS = 32'd200;
  localparam logic [31:0] ESCAPE_MS  = 32'd600;
  localparam logic [31:0] PD_GAP_MS  = 32'd1;

  localparam int TURN_SPD    = 80;
  localparam int ARC_OUT_SPD = 90;
  localparam int ARC_IN_SPD  = 20;
  localparam int SPD_LIMIT   = 100;

  typedef enum logic [1:0] {
    MODE_OPENING = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_ESCAPE  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]         action;
    logic               line_left;
    logic               line_right;
    logic               rival_seen;
    logic signed [15:0] position_error;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] left_speed;
    logic signed [7:0] right_speed;
    logic              motor_update;
    logic [1:0]        led_mode;
    logic [1:0]        mode_now;
    logic              match_on;
  } out_item_t;

  typedef struct packed {
    logic [2:0] opening_kind;
    logic [1:0] strategy_kind;
    logic [7:0] prop_gain;
    logic [7:0] deriv_gain;
    logic [6:0] cruise_speed;
    logic [6:0] escape_speed;
  } cfg_t;

  function automatic logic signed [7:0] sat100(input wide_t v);
    logic signed [7:0] r;
    if (v > wide_t'(SPD_LIMIT)) begin
      r = 8'sd100;
    end else if (v < -wide_t'(SPD_LIMIT)) begin
      r = -8'sd100;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rms_cfg.sv =====
// Configuration register file for the robot mode sequencer.
`timescale 1ns / 1ps
`default_nettype none

module rms_cfg
  import rms_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  wire logic [2:0] wr_index,
  input  wire logic [7:0] wr_data,
  output cfg_t            cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.opening_kind  <= OPEN_FRONT;
      cfg.strategy_kind <= STRAT_PD;
      cfg.prop_gain     <= 8'd1;
      cfg.deriv_gain    <= 8'd0;
      cfg.cruise_speed  <= 7'd50;
      cfg.escape_speed  <= 7'd50;
    end else if (wr_en) begin
      case (wr_index)
        REG_OPENING_KIND:  cfg.opening_kind  <= wr_data[2:0];
        REG_STRATEGY_KIND: cfg.strategy_kind <= wr_data[1:0];
        REG_PROP_GAIN:     cfg.prop_gain     <= wr_data;
        REG_DERIV_GAIN:    cfg.deriv_gain    <= wr_data;
        REG_CRUISE_SPEED:  cfg.cruise_speed  <= wr_data[6:0];
        REG_ESCAPE_SPEED:  cfg.escape_speed  <= wr_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rms_pd.sv =====
// PD steering correction and saturated wheel speeds.
`timescale 1ns / 1ps
`default_nettype none

module rms_pd
  import rms_pkg::*;
(
  input  wire logic signed [15:0] err,
  input  wire logic signed [15:0] last_err,
  input  wire logic [7:0]         prop_gain,
  input  wire logic [7:0]         deriv_gain,
  input  wire logic [6:0]         cruise_speed,
  output logic signed [7:0]       left_speed,
  output logic signed [7:0]       right_speed
);

  logic signed [16:0] diff;
  logic signed [24:0] p_term;
  logic signed [25:0] d_term;
  wide_t              corr;
  wide_t              base_w;

  always_comb begin
    diff        = {err[15], err} - {last_err[15], last_err};
    p_term      = err * $signed({1'b0, prop_gain});
    d_term      = diff * $signed({1'b0, deriv_gain});
    corr        = wide_t'(p_term) + wide_t'(d_term);
    base_w      = wide_t'({1'b0, cruise_speed});
    left_speed  = sat100(base_w + corr);
    right_speed = sat100(base_w - corr);
  end

endmodule

`default_nettype wire

// ===== hdl/rms_seq.sv =====
// Mode sequencer state and per-transaction decision logic.
`timescale 1ns / 1ps
`default_nettype none

module rms_seq
  import rms_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     fire,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output out_item_t     res
);

  logic              match_started, match_next;
  mode_t             mode_reg, mode_next;
  mode_t             previous_mode, prev_next;
  logic [31:0]       ms_counter, ms_next;
  logic [31:0]       mode_entry_ms, entry_next;
  logic [31:0]       last_pd_ms, last_pd_next;
  logic signed [15:0] last_error, last_error_next;
  logic signed [7:0] held_left, held_left_next;
  logic signed [7:0] held_right, held_right_next;

  logic signed [7:0] pd_left, pd_right;
  logic [31:0]       ms_inc, elapsed, limit;
  mode_t             m1, prev1;
  logic [31:0]       entry1;
  logic              upd, timed;
  logic [1:0]        led;
  wide_t             mv_l, mv_r, turn_w, base_w;

  rms_pd u_pd (
    .err          (item.position_error),
    .last_err     (last_error),
    .prop_gain    (cfg.prop_gain),
    .deriv_gain   (cfg.deriv_gain),
    .cruise_speed (cfg.cruise_speed),
    .left_speed   (pd_left),
    .right_speed  (pd_right)
  );

  always_comb begin
    match_next      = match_started;
    mode_next       = mode_reg;
    prev_next       = previous_mode;
    ms_next         = ms_counter;
    entry_next      = mode_entry_ms;
    last_pd_next    = last_pd_ms;
    last_error_next = last_error;
    held_left_next  = held_left;
    held_right_next = held_right;
    upd             = 1'b0;
    led             = LED_NONE;
    timed           = 1'b0;
    limit           = TURN_MS;
    mv_l            = '0;
    mv_r            = '0;
    ms_inc          = ms_counter + 32'd1;
    turn_w          = wide_t'({1'b0, cfg.escape_speed});
    base_w          = wide_t'({1'b0, cfg.cruise_speed});

    if (mode_reg != MODE_ESCAPE && (item.line_left || item.line_right)) begin
      m1     = MODE_ESCAPE;
      prev1  = mode_reg;
      entry1 = ms_inc;
    end else begin
      m1     = mode_reg;
      prev1  = previous_mode;
      entry1 = mode_entry_ms;
    end
    elapsed = ms_inc - entry1;

    case (item.action)
      ACT_TICK: begin
        ms_next = ms_inc;
        if (!match_started) begin
          held_left_next  = '0;
          held_right_next = '0;
          upd             = 1'b1;
        end else begin
          mode_next  = m1;
          prev_next  = prev1;
          entry_next = entry1;
          case (m1)
            MODE_RUNNING: begin
              led = LED_SOLID;
              if (cfg.strategy_kind == STRAT_STRAIGHT) begin
                held_left_next  = sat100(base_w);
                held_right_next = sat100(base_w);
                upd             = 1'b1;
              end else if (cfg.strategy_kind == STRAT_PD) begin
                if (ms_inc - last_pd_ms > PD_GAP_MS) begin
                  held_left_next  = pd_left;
                  held_right_next = pd_right;
                  upd             = 1'b1;
                  last_error_next = item.position_error;
                  last_pd_next    = ms_inc;
                end
              end else begin
                held_left_next  = '0;
                held_right_next = '0;
                upd             = 1'b1;
              end
            end
            MODE_OPENING: begin
              led = LED_FAST;
              case (cfg.opening_kind)
                OPEN_FRONT: begin
                  prev_next  = m1;
                  mode_next  = MODE_RUNNING;
                  entry_next = ms_inc;
                end
                OPEN_RIGHT: begin
                  timed = 1'b1;
                  limit = TURN_MS;
                  mv_l  = wide_t'(TURN_SPD);
                  mv_r  = -wide_t'(TURN_SPD);
                end
                OPEN_RIGHT_ARC: begin
                  timed = 1'b1;
                  limit = ARC_MS;
                  mv_l  = wide_t'(ARC_OUT_SPD);
                  mv_r  = wide_t'(ARC_IN_SPD);
                end
                OPEN_LEFT: begin
                  timed = 1'b1;
                  limit = TURN_MS;
                  mv_l  = -wide_t'(TURN_SPD);
                  mv_r  = wide_t'(TURN_SPD);
                end
                OPEN_LEFT_ARC: begin
                  timed = 1'b1;
                  limit = ARC_MS;
                  mv_l  = wide_t'(ARC_IN_SPD);
                  mv_r  = wide_t'(ARC_OUT_SPD);
                end
                OPEN_BACK: begin
                  timed = 1'b1;
                  limit = BACK_MS;
                  mv_l  = wide_t'(TURN_SPD);
                  mv_r  = -wide_t'(TURN_SPD);
                end
                default: begin
                  held_left_next  = '0;
                  held_right_next = '0;
                  upd             = 1'b1;
                end
              endcase
              if (timed) begin
                if (elapsed <= limit && !item.rival_seen) begin
                  held_left_next  = sat100(mv_l);
                  held_right_next = sat100(mv_r);
                  upd             = 1'b1;
                end else begin
                  prev_next  = m1;
                  mode_next  = MODE_RUNNING;
                  entry_next = ms_inc;
                end
              end
            end
            MODE_ESCAPE: begin
              led = LED_SLOW;
              if (elapsed <= REVERSE_MS) begin
                held_left_next  = sat100(-turn_w);
                held_right_next = sat100(-turn_w);
                upd             = 1'b1;
              end else if (elapsed <= ESCAPE_MS && !item.rival_seen) begin
                held_left_next  = sat100(turn_w);
                held_right_next = sat100(-turn_w);
                upd             = 1'b1;
              end else begin
                prev_next  = m1;
                mode_next  = prev1;
                entry_next = ms_inc;
              end
            end
            default: begin
              held_left_next  = '0;
              held_right_next = '0;
              upd             = 1'b1;
            end
          endcase
        end
      end
      ACT_START: begin
        match_next = 1'b1;
        prev_next  = mode_reg;
        mode_next  = MODE_OPENING;
        entry_next = ms_counter;
      end
      ACT_STOP: begin
        match_next = 1'b0;
      end
      default: ;
    endcase

    res.left_speed   = held_left_next;
    res.right_speed  = held_right_next;
    res.motor_update = upd;
    res.led_mode     = led;
    res.mode_now     = mode_next;
    res.match_on     = match_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_started <= 1'b0;
      mode_reg      <= MODE_OPENING;
      previous_mode <= MODE_OPENING;
      ms_counter    <= '0;
      mode_entry_ms <= '0;
      last_pd_ms    <= '0;
      last_error    <= '0;
      held_left     <= '0;
      held_right    <= '0;
    end else if (fire) begin
      match_started <= match_next;
      mode_reg      <= mode_next;
      previous_mode <= prev_next;
      ms_counter    <= ms_next;
      mode_entry_ms <= entry_next;
      last_pd_ms    <= last_pd_next;
      last_error    <= last_error_next;
      held_left     <= held_left_next;
      held_right    <= held_right_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/robot_mode_sequencer_pd_steer_core.sv =====
// Top level of the robot mode sequencer with PD steering.
//
//   channel  direction  handshake               payload
//   item     in         item_valid / item_stall  in_item_t
//   result   out        result_valid / result_stall  out_item_t
//   cfg      in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One transaction per cycle while the result is not stalled; an item goes
// via the input register and the sequencer pass into the result register.
// The sequencer state is updated in the same pass, so each transaction sees
// the state its predecessor left. Reset clears the pipeline valids, the state
// and the configuration to their defaults. A stalled result holds the pass,
// and the input register stalls only once it too is full.
`timescale 1ns / 1ps
`default_nettype none

module robot_mode_sequencer_pd_steer_core
  import rms_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire in_item_t   item,
  output logic            result_valid,
  input  wire logic       result_stall,
  output out_item_t       result,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  cfg_t      cfg;
  in_item_t  held_item;
  logic      held_valid;
  logic      out_free;
  logic      fire;
  logic      take;
  out_item_t res_next;

  assign cfg_ready  = 1'b1;
  assign out_free   = !result_valid || !result_stall;
  assign fire       = held_valid && out_free;
  assign item_stall = held_valid && !out_free;
  assign take       = item_valid && !item_stall;

  rms_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  rms_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (held_item),
    .cfg  (cfg),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      held_valid <= take || (held_valid && !fire);
      if (out_free) begin
        result_valid <= fire;
      end
    end
    if (take) begin
      held_item <= item;
    end
    if (fire) begin
      result <= res_next;
    end
  end

endmodule

`default_nettype wire
